FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, ignored while reset is active.
`define W2S_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("w2s check failed");

// Concurrent check that also holds during reset.
`define W2S_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("w2s check failed");

`endif

FILE: rtl/w2s_pkg.sv
// Types, constants and helpers for the world-to-screen projection.
`default_nettype none
package w2s_pkg;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int SUM_W     = 46;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 4'd7;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [12:0]        view_width;
        logic [12:0]        view_height;
    } in_item_t;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(S32_MAX))
            r = S32_MAX;
        else if (v < SUM_W'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/w2s_if.sv
// Valid/ready channels for input points and screen results.
`default_nettype none
interface w2s_in_if;
    logic               valid;
    logic               ready;
    w2s_pkg::in_item_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface w2s_out_if;
    logic               valid;
    logic               ready;
    w2s_pkg::out_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/w2s_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage.
`default_nettype none
module w2s_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [66-FRAC_BITS-1:0] num,
    input  wire logic signed [66-FRAC_BITS-1:0] den,
    output logic signed [31:0]               quo
);
    import w2s_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;
    localparam int NW     = CLIP_W + FRAC_BITS;
    localparam int WW     = CLIP_W + 32;

    logic [NW-1:0]     rem_reg [33];
    logic [CLIP_W-1:0] den_reg [33];
    logic [31:0]       q_reg   [33];
    logic              neg_reg [33];
    logic              ovf_reg [33];
    logic signed [31:0] quo_reg;

    logic [CLIP_W-1:0] mag;
    logic [NW-1:0]     rem_next;

    always_comb
    begin
        mag      = num[CLIP_W-1] ? CLIP_W'(-num) : CLIP_W'(num);
        rem_next = {mag, {FRAC_BITS{1'b0}}};
    end

    // Integer part too large for the result format: saturate.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[CLIP_W-1];
            ovf_reg[0] <= WW'(rem_next) >= (WW'(den) << 32);
        end
    end

    for (genvar k = 1; k <= 32; k++)
    begin : g_bit
        localparam int B = 32 - k;
        logic [WW-1:0] trial;
        logic [WW-1:0] diff;
        logic          ge;

        always_comb
        begin
            trial = WW'(den_reg[k-1]) << B;
            ge    = WW'(rem_reg[k-1]) >= trial;
            diff  = WW'(rem_reg[k-1]) - trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[NW-1:0] : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][30:0], ge};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[32])
                quo_reg <= neg_reg[32] ? S32_MIN : S32_MAX;
            else if (!neg_reg[32])
                quo_reg <= q_reg[32][31] ? S32_MAX : $signed(q_reg[32]);
            else if (q_reg[32] > 32'h8000_0000)
                quo_reg <= S32_MIN;
            else
                quo_reg <= $signed(-q_reg[32]);
        end
    end

    assign quo = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/world_to_screen_projection.sv
// Top level of the world-to-screen perspective projection pipeline.
// Takes one world point per cycle while the output is not stalled and returns
// one screen result per point, in order. The clip-space divider, which resolves
// one quotient bit per stage for 32 stages, makes up most of the pipeline. A
// stall on the output holds every stage; input ready follows output ready
// whenever the output register is full. Matrix registers must be written only
// while no point is in flight.
`default_nettype none
module world_to_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [w2s_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [w2s_pkg::CFG_W-1:0]        cfg_data,
    w2s_in_if.sink                                 point,
    w2s_out_if.source                              screen
);
    import w2s_pkg::*;

    localparam int CLIP_W  = 66 - FRAC_BITS;
    localparam int DIV_LAT = 34;
    localparam int NV      = 3 + DIV_LAT + 2;
    localparam logic signed [CLIP_W-1:0] THRESH = CLIP_W'(((1 << FRAC_BITS) + 5) / 10);

    logic [CFG_W-1:0] mat_reg [NUM_REGS];
    logic [NV-1:0]    vld_reg;
    logic             adv;

    // stage A
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [11:0]        hwa_reg, hha_reg;
    // stage B
    logic signed [63:0] prod_reg [9];
    logic [11:0]        hwb_reg, hhb_reg;
    // stage C
    logic signed [CLIP_W-1:0] cx_reg, cy_reg, cw_reg;
    logic                     visc_reg;
    logic [11:0]              hwc_reg, hhc_reg;
    // alongside divider
    logic        sv_reg [DIV_LAT];
    logic [11:0] sw_reg [DIV_LAT];
    logic [11:0] sh_reg [DIV_LAT];
    logic signed [31:0] nx, ny;
    // stage D
    logic signed [44:0] mx_reg, my_reg;
    logic               visd_reg;
    logic [11:0]        hwd_reg, hhd_reg;
    // stage E
    out_item_t out_reg;

    logic signed [63:0]       prod_next [9];
    logic signed [CLIP_W-1:0] clip_next [3];
    logic signed [SUM_W-1:0]  sx_sum, sy_sum;

    assign adv          = !vld_reg[NV-1] || screen.ready;
    assign point.ready  = adv;
    assign screen.valid = vld_reg[NV-1];
    assign screen.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                mat_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NV-2:0], point.valid};
    end

    always_comb
    begin
        prod_next[0] = $signed(mat_reg[REG_ROW0_C01[2:0]][31:0])  * px_reg;
        prod_next[1] = $signed(mat_reg[REG_ROW0_C01[2:0]][63:32]) * py_reg;
        prod_next[2] = $signed(mat_reg[REG_ROW0_C23[2:0]][31:0])  * pz_reg;
        prod_next[3] = $signed(mat_reg[REG_ROW1_C01[2:0]][31:0])  * px_reg;
        prod_next[4] = $signed(mat_reg[REG_ROW1_C01[2:0]][63:32]) * py_reg;
        prod_next[5] = $signed(mat_reg[REG_ROW1_C23[2:0]][31:0])  * pz_reg;
        prod_next[6] = $signed(mat_reg[REG_ROW3_C01[2:0]][31:0])  * px_reg;
        prod_next[7] = $signed(mat_reg[REG_ROW3_C01[2:0]][63:32]) * py_reg;
        prod_next[8] = $signed(mat_reg[REG_ROW3_C23[2:0]][31:0])  * pz_reg;
    end

    // Floor-shift each product, then add the translation coefficient.
    always_comb
    begin
        clip_next[0] = CLIP_W'((prod_reg[0] >>> FRAC_BITS) + (prod_reg[1] >>> FRAC_BITS)
            + (prod_reg[2] >>> FRAC_BITS) + 64'($signed(mat_reg[REG_ROW0_C23[2:0]][63:32])));
        clip_next[1] = CLIP_W'((prod_reg[3] >>> FRAC_BITS) + (prod_reg[4] >>> FRAC_BITS)
            + (prod_reg[5] >>> FRAC_BITS) + 64'($signed(mat_reg[REG_ROW1_C23[2:0]][63:32])));
        clip_next[2] = CLIP_W'((prod_reg[6] >>> FRAC_BITS) + (prod_reg[7] >>> FRAC_BITS)
            + (prod_reg[8] >>> FRAC_BITS) + 64'($signed(mat_reg[REG_ROW3_C23[2:0]][63:32])));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= point.data.point_x;
            py_reg  <= point.data.point_y;
            pz_reg  <= point.data.point_z;
            hwa_reg <= point.data.view_width[12:1];
            hha_reg <= point.data.view_height[12:1];

            for (int i = 0; i < 9; i++)
                prod_reg[i] <= prod_next[i];
            hwb_reg <= hwa_reg;
            hhb_reg <= hha_reg;

            cx_reg   <= clip_next[0];
            cy_reg   <= clip_next[1];
            cw_reg   <= clip_next[2];
            visc_reg <= !(clip_next[2] < THRESH);
            hwc_reg  <= hwb_reg;
            hhc_reg  <= hhb_reg;

            sv_reg[0] <= visc_reg;
            sw_reg[0] <= hwc_reg;
            sh_reg[0] <= hhc_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
                sw_reg[i] <= sw_reg[i-1];
                sh_reg[i] <= sh_reg[i-1];
            end

            mx_reg   <= $signed({1'b0, sw_reg[DIV_LAT-1]}) * nx;
            my_reg   <= $signed({1'b0, sh_reg[DIV_LAT-1]}) * ny;
            visd_reg <= sv_reg[DIV_LAT-1];
            hwd_reg  <= sw_reg[DIV_LAT-1];
            hhd_reg  <= sh_reg[DIV_LAT-1];

            out_reg.visible  <= visd_reg;
            out_reg.screen_x <= visd_reg ? sat32(sx_sum) : '0;
            out_reg.screen_y <= visd_reg ? sat32(sy_sum) : '0;
        end
    end

    always_comb
    begin
        sx_sum = SUM_W'(mx_reg) + SUM_W'($signed({1'b0, hwd_reg, {FRAC_BITS{1'b0}}}));
        sy_sum = SUM_W'($signed({1'b0, hhd_reg, {FRAC_BITS{1'b0}}})) - SUM_W'(my_reg);
    end

    w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk (clk),
        .en  (adv),
        .num (cx_reg),
        .den (cw_reg),
        .quo (nx)
    );

    w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk (clk),
        .en  (adv),
        .num (cy_reg),
        .den (cw_reg),
        .quo (ny)
    );
endmodule
`default_nettype wire

FILE: rtl/w2s_check.sv
// Port-level checks for the projection block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module w2s_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_visible,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y
);
    // A hidden point reports the origin.
    `W2S_ASSERT(a_hidden_zero, clk, rst_n, (out_valid && !out_visible) |-> (out_x == 32'd0 && out_y == 32'd0))
    // A drained output never blocks the input side.
    `W2S_ASSERT(a_ready_flow, clk, rst_n, out_ready |-> in_ready)
    // Hold a stalled beat.
    `W2S_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    `W2S_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid)
endmodule

bind world_to_screen_projection w2s_check u_w2s_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (point.ready),
    .out_valid   (screen.valid),
    .out_ready   (screen.ready),
    .out_visible (screen.data.visible),
    .out_x       (screen.data.screen_x),
    .out_y       (screen.data.screen_y)
);
`default_nettype wire
